>>> src/ntep_pkg.sv
// ----------------------------------------------------------------------------
// Nearest-template predictor package
// Shared widths, the template table, the search beat type and the sequencer
// states used by the cell row, the divider and the top level.
// ----------------------------------------------------------------------------
package ntep_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int MAG_W         = 15;
    localparam int ROM_W         = 13;
    localparam int IDX_W         = 5;
    localparam int ALPHA_W       = 16;
    localparam int MAX_WINDOW    = 16;
    localparam int MAX_TEMPLATES = 25;
    localparam int COL_W         = $clog2(MAX_WINDOW);
    // Widest L1 distance: MAX_WINDOW entries of up to 2^MAG_W - 1 each.
    localparam int DIST_W        = MAG_W + $clog2(MAX_WINDOW);

    localparam int WINDOW_LEN_DEF     = 16;
    localparam int TEMPLATE_COUNT_DEF = 25;

    localparam logic [ALPHA_W-1:0] SMOOTHING_RESET = 16'd1311;

    // Template levels in Q1.12, row = template, column = window age.
    localparam logic [ROM_W-1:0] ROM_TABLE [MAX_TEMPLATES][MAX_WINDOW] = '{
        '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0},
        '{1229,1229,1229,1229,1229,1229,1229,1229,
          1229,1229,1229,1229,1229,1229,1229,1229},
        '{2458,2458,2458,2458,2458,2458,2458,2458,
          2458,2458,2458,2458,2458,2458,2458,2458},
        '{3277,3277,3277,3277,3277,3277,3277,3277,
          3277,3277,3277,3277,3277,3277,3277,3277},
        '{0,49,205,463,819,1278,1843,2511,3277,4096,4096,4096,4096,4096,4096,4096},
        '{0,0,49,205,463,819,1278,1843,2511,3277,4096,4096,4096,4096,4096,4096},
        '{0,0,0,49,205,463,819,1278,1843,2511,3277,4096,4096,4096,4096,4096},
        '{0,0,0,0,49,205,463,819,1278,1843,2511,3277,4096,4096,4096,4096},
        '{0,0,0,0,0,49,205,463,819,1278,1843,2511,3277,4096,4096,4096},
        '{0,0,0,0,0,0,49,205,463,819,1278,1843,2511,3277,4096,4096},
        '{0,0,0,0,0,0,0,49,205,463,819,1278,1843,2511,3277,4096},
        '{0,102,410,922,1638,2560,3686,4096,4096,4096,4096,4096,4096,4096,4096,4096},
        '{0,205,819,1843,3277,4096,4096,4096,4096,4096,4096,4096,4096,4096,4096,4096},
        '{0,410,1638,3686,4096,4096,4096,4096,4096,4096,4096,4096,4096,4096,4096,4096},
        '{0,0,410,1638,3686,4096,4096,4096,4096,4096,4096,4096,4096,4096,4096,4096},
        '{0,0,0,410,1638,3686,4096,4096,4096,4096,4096,4096,4096,4096,4096,4096},
        '{0,0,0,0,410,1638,3686,4096,4096,4096,4096,4096,4096,4096,4096,4096},
        '{0,0,0,0,0,410,1638,3686,4096,4096,4096,4096,4096,4096,4096,4096},
        '{0,0,0,0,0,0,410,1638,3686,4096,4096,4096,4096,4096,4096,4096},
        '{0,0,0,0,0,0,0,410,1638,3686,4096,4096,4096,4096,4096,4096},
        '{0,0,0,0,0,0,0,0,410,1638,3686,4096,4096,4096,4096,4096},
        '{0,0,0,0,0,0,0,0,0,410,1638,3686,4096,4096,4096,4096},
        '{0,0,0,0,0,0,0,0,0,0,410,1638,3686,4096,4096,4096},
        '{0,0,0,0,0,0,0,0,0,0,0,410,1638,3686,4096,4096},
        '{0,0,0,0,0,0,0,0,0,0,0,0,410,1638,3686,4096}
    };

    // One template travelling along the cell row with its partial distance.
    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  tidx;
        logic [DIST_W-1:0] l1;
    } t_lane;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_WAIT,
        S_MUL,
        S_ADD,
        S_OUT
    } t_state;

    function automatic logic [ROM_W-1:0] rom_value(
        input logic [IDX_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [ROM_W-1:0] v;
        v = '0;
        if (row < IDX_W'(MAX_TEMPLATES)) begin
            v = ROM_TABLE[row][col];
        end
        return v;
    endfunction

endpackage

>>> src/ntep_cell.sv
// ----------------------------------------------------------------------------
// Nearest-template predictor cell
// Holds one window entry and adds its distance to one template column onto
// the partial sum handed over by the previous cell.
// ----------------------------------------------------------------------------
module ntep_cell #(
    parameter int COL = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic [ntep_pkg::MAG_W-1:0]   i_win,
    output logic [ntep_pkg::MAG_W-1:0]   o_win,
    input  ntep_pkg::t_lane              i_lane,
    output ntep_pkg::t_lane              o_lane
);

    logic [ntep_pkg::MAG_W-1:0] r_win;
    logic [ntep_pkg::MAG_W-1:0] n_win;
    ntep_pkg::t_lane            r_lane;
    ntep_pkg::t_lane            n_lane;
    logic [ntep_pkg::MAG_W-1:0] w_tpl;
    logic [ntep_pkg::MAG_W-1:0] w_diff;

    always_comb begin
        w_tpl  = ntep_pkg::MAG_W'(ntep_pkg::rom_value(i_lane.tidx,
                                                      ntep_pkg::COL_W'(COL)));
        w_diff = (r_win >= w_tpl) ? (r_win - w_tpl) : (w_tpl - r_win);
        n_lane.vld  = i_lane.vld;
        n_lane.tidx = i_lane.tidx;
        n_lane.l1   = i_lane.l1 + ntep_pkg::DIST_W'(w_diff);
        n_win       = i_shift ? i_win : r_win;
    end

    always_ff @(posedge i_clk) begin
        r_lane.tidx <= n_lane.tidx;
        r_lane.l1   <= n_lane.l1;
        if (!i_rst_n) begin
            r_win      <= '0;
            r_lane.vld <= 1'b0;
        end else begin
            r_win      <= n_win;
            r_lane.vld <= n_lane.vld;
        end
    end

    assign o_win  = r_win;
    assign o_lane = r_lane;

endmodule

>>> src/ntep_div.sv
// ----------------------------------------------------------------------------
// Nearest-template predictor mean divider
// Division by a constant through multiplication with a rounded-up reciprocal,
// exact over the whole dividend range, with the quotient registered in the cycle
// after the start.
// ----------------------------------------------------------------------------
module ntep_div #(
    parameter int DIVISOR = ntep_pkg::WINDOW_LEN_DEF,
    parameter int W       = ntep_pkg::DIST_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    output logic         o_done,
    output logic [W-1:0] o_quot
);

    localparam int     SHIFT   = W + $clog2(DIVISOR);
    localparam int     RECIP_W = W + 1;
    localparam int     PROD_W  = W + RECIP_W;
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                                 / longint'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic              r_done;
    logic [W-1:0]      r_quot;
    logic [PROD_W-1:0] w_prod;

    always_comb begin
        w_prod = PROD_W'(i_dividend) * PROD_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= W'(w_prod >> SHIFT);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> src/nearest_template_ema_predictor.sv
// ----------------------------------------------------------------------------
// Nearest-template predictor with per-template exponential averaging
// Window of sample magnitudes held in a row of cells, templates streamed
// through the row one per cycle, level update by a two-stage multiply-add.
// ----------------------------------------------------------------------------
// The wait from the accepted input beat to the result beat is set by the template
// stream through the cell row. Throughput: one item at a time; the next sample
// beat is taken once the previous result is in the output register. Reset
// (synchronous, active low) zeroes the window and all template levels and loads
// smoothing with 1311.
// ----------------------------------------------------------------------------
module nearest_template_ema_predictor #(
    parameter int WINDOW_LEN     = ntep_pkg::WINDOW_LEN_DEF,
    parameter int TEMPLATE_COUNT = ntep_pkg::TEMPLATE_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel: the smoothing weight in Q0.16.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ntep_pkg::ALPHA_W-1:0]        i_cfg_data,
    // Sample channel.
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic signed [ntep_pkg::SAMPLE_W-1:0] i_sample,
    // Result channel.
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic signed [ntep_pkg::SAMPLE_W-1:0] o_prediction,
    output logic [ntep_pkg::IDX_W-1:0]          o_winner
);

    localparam int LVL_IW = (TEMPLATE_COUNT > 1) ? $clog2(TEMPLATE_COUNT) : 1;
    localparam int MAG_W  = ntep_pkg::MAG_W;
    localparam int IDX_W  = ntep_pkg::IDX_W;
    localparam int DIST_W = ntep_pkg::DIST_W;

    // ------------------------------------------------------------------
    // Sequencer. An accepted beat shifts the window one place along the
    // cell row; the FEED state then injects one template index per cycle
    // at the head of the row. Once every distance has come out of the tail
    // and the mean is ready, MUL and ADD update the winner's level and OUT
    // hands the result to the output register.
    // ------------------------------------------------------------------
    ntep_pkg::t_state r_state;
    ntep_pkg::t_state n_state;
    logic [IDX_W-1:0] r_feed_cnt;
    logic             w_accept;
    logic             w_feed_vld;
    logic             w_load_out;
    logic             w_out_free;

    logic             r_scan_done;
    logic             r_mean_ok;

    assign w_accept   = i_sample_valid && o_sample_ready;
    assign w_out_free = !o_result_valid || i_result_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ntep_pkg::S_IDLE: begin
                if (i_sample_valid) begin
                    n_state = ntep_pkg::S_FEED;
                end
            end
            ntep_pkg::S_FEED: begin
                if (r_feed_cnt == IDX_W'(TEMPLATE_COUNT - 1)) begin
                    n_state = ntep_pkg::S_WAIT;
                end
            end
            ntep_pkg::S_WAIT: begin
                if (r_scan_done && r_mean_ok) begin
                    n_state = ntep_pkg::S_MUL;
                end
            end
            ntep_pkg::S_MUL: begin
                n_state = ntep_pkg::S_ADD;
            end
            ntep_pkg::S_ADD: begin
                n_state = ntep_pkg::S_OUT;
            end
            ntep_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = ntep_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ntep_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_sample_ready = 1'b0;
        w_feed_vld     = 1'b0;
        w_load_out     = 1'b0;
        unique case (r_state)
            ntep_pkg::S_IDLE: o_sample_ready = 1'b1;
            ntep_pkg::S_FEED: w_feed_vld     = 1'b1;
            ntep_pkg::S_OUT:  w_load_out     = w_out_free;
            default: begin
                o_sample_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ntep_pkg::S_IDLE;
            r_feed_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_feed_cnt <= '0;
            end else if (w_feed_vld) begin
                r_feed_cnt <= r_feed_cnt + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration register. Writes must arrive only while the block is idle, a rule
    // for the user that the block itself does not enforce; the port is always ready.
    // ------------------------------------------------------------------
    logic [ntep_pkg::ALPHA_W-1:0] r_alpha;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ntep_pkg::SMOOTHING_RESET;
        end else if (i_cfg_valid) begin
            r_alpha <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Sample magnitude with saturation of the most negative code, and the
    // sign facts that shape the prediction.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] w_mag;
    logic             r_zero;
    logic             r_neg;

    always_comb begin
        if (i_sample[ntep_pkg::SAMPLE_W-1]) begin
            if (i_sample == 16'sh8000) begin
                w_mag = '1;
            end else begin
                w_mag = MAG_W'(-i_sample);
            end
        end else begin
            w_mag = MAG_W'(i_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_zero <= (i_sample == '0);
            r_neg  <= i_sample[ntep_pkg::SAMPLE_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Cell row. Cell k holds the window entry of age k and compares it with
    // column k of whichever template is passing through it.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] w_win  [WINDOW_LEN];
    ntep_pkg::t_lane  w_lane [WINDOW_LEN];
    ntep_pkg::t_lane  w_feed;
    ntep_pkg::t_lane  w_tail;

    always_comb begin
        w_feed.vld  = w_feed_vld;
        w_feed.tidx = r_feed_cnt;
        w_feed.l1   = '0;
    end

    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
        if (k == 0) begin : g_head
            ntep_cell #(
                .COL (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_win   (w_mag),
                .o_win   (w_win[k]),
                .i_lane  (w_feed),
                .o_lane  (w_lane[k])
            );
        end else begin : g_body
            ntep_cell #(
                .COL (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_win   (w_win[k-1]),
                .o_win   (w_win[k]),
                .i_lane  (w_lane[k-1]),
                .o_lane  (w_lane[k])
            );
        end
    end

    assign w_tail = w_lane[WINDOW_LEN-1];

    // ------------------------------------------------------------------
    // Minimum search at the tail of the row. A strict less-than keeps the
    // lowest index on a tie. Template 0 is all zeros, so its distance is
    // the window sum itself, which starts the mean divider. The divider registers
    // the mean in the following cycle, long before the last template leaves the row.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  r_best;
    logic [DIST_W-1:0] r_best_dist;
    logic              w_div_start;
    logic              w_div_done;
    logic [DIST_W-1:0] w_quot;

    assign w_div_start = w_tail.vld && (w_tail.tidx == '0);

    always_ff @(posedge i_clk) begin
        if (w_tail.vld && ((w_tail.tidx == '0) || (w_tail.l1 < r_best_dist))) begin
            r_best      <= w_tail.tidx;
            r_best_dist <= w_tail.l1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_done <= 1'b0;
            r_mean_ok   <= 1'b0;
        end else if (w_accept) begin
            r_scan_done <= 1'b0;
            r_mean_ok   <= 1'b0;
        end else begin
            if (w_tail.vld && (w_tail.tidx == IDX_W'(TEMPLATE_COUNT - 1))) begin
                r_scan_done <= 1'b1;
            end
            if (w_div_done) begin
                r_mean_ok <= 1'b1;
            end
        end
    end

    ntep_div #(
        .DIVISOR (WINDOW_LEN),
        .W       (DIST_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_tail.l1),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // ------------------------------------------------------------------
    // Level update: level' = (level * (65536 - alpha) + alpha * mean
    // + 32768) >> 16, i.e. an exponential average rounded half up. The two
    // products are registered in MUL and summed in ADD.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] r_level [TEMPLATE_COUNT];
    logic [31:0]      r_prod_old;
    logic [30:0]      r_prod_new;
    logic [MAG_W-1:0] r_new_level;
    logic [16:0]      w_keep;
    logic [MAG_W-1:0] w_mean;
    logic [MAG_W-1:0] w_cur_level;
    logic [32:0]      w_acc;
    logic [16:0]      w_acc_hi;
    logic [MAG_W-1:0] w_upd_level;
    logic [LVL_IW-1:0] w_best_idx;

    always_comb begin
        w_best_idx  = r_best[LVL_IW-1:0];
        w_keep      = 17'h10000 - 17'(r_alpha);
        w_mean      = MAG_W'(w_quot);
        w_cur_level = r_level[w_best_idx];
        w_acc       = 33'(r_prod_old) + 33'(r_prod_new) + 33'd32768;
        w_acc_hi    = w_acc[32:16];
        w_upd_level = (w_acc_hi > 17'd32767) ? '1 : MAG_W'(w_acc_hi);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ntep_pkg::S_MUL) begin
            r_prod_old <= 32'(w_cur_level) * 32'(w_keep);
            r_prod_new <= 31'(r_alpha) * 31'(w_mean);
        end
        if (r_state == ntep_pkg::S_ADD) begin
            r_new_level <= w_upd_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TEMPLATE_COUNT; t++) begin
                r_level[t] <= '0;
            end
        end else if (r_state == ntep_pkg::S_ADD) begin
            r_level[w_best_idx] <= w_upd_level;
        end
    end

    // ------------------------------------------------------------------
    // Output register. It parts the result channel from the sequencer, so
    // the next sample beat is taken while a result still waits.
    // ------------------------------------------------------------------
    logic                                 r_out_vld;
    logic signed [ntep_pkg::SAMPLE_W-1:0] r_pred;
    logic [IDX_W-1:0]                     r_winner;
    logic signed [ntep_pkg::SAMPLE_W-1:0] w_pred;

    always_comb begin
        if (r_zero) begin
            w_pred = '0;
        end else if (r_neg) begin
            w_pred = {1'b0, r_new_level};
        end else begin
            w_pred = ~{1'b0, r_new_level} + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_result_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_pred   <= w_pred;
            r_winner <= r_best;
        end
    end

    assign o_result_valid = r_out_vld;
    assign o_prediction   = r_pred;
    assign o_winner       = r_winner;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_tail_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ntep_pkg::S_IDLE) |-> !w_tail.vld)
        else $error("template distance left the cell row while idle");

    a_mean_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ntep_pkg::S_WAIT) && r_scan_done) |-> r_mean_ok)
        else $error("template search finished before the window mean");

    a_mul_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ntep_pkg::S_MUL) |-> (r_scan_done && r_mean_ok))
        else $error("level update began before search and mean were complete");

    a_winner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_winner < IDX_W'(TEMPLATE_COUNT)))
        else $error("winner index beyond the template count");

endmodule
